// File: hw/rtl/ptts_pkg.sv
// ptts_pkg: shared types and constants for the pin toggle test sequencer
// used by ptts_core and pin_toggle_test_sequencer_top; no dependencies
package ptts_pkg;

  localparam int unsigned CmdW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HighW = 7;
  localparam int unsigned LowW  = 8;
  localparam int unsigned LedW  = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;

  // master command words
  localparam logic [CmdW-1:0] CMD_INIT  = 16'd0;
  localparam logic [CmdW-1:0] CMD_PASS  = 16'd1;
  localparam logic [CmdW-1:0] CMD_FAIL  = 16'd2;
  localparam logic [CmdW-1:0] CMD_START = 16'd3;

  // led commands
  localparam logic [LedW-1:0] LED_NONE  = 2'd0;
  localparam logic [LedW-1:0] LED_OFF   = 2'd1;
  localparam logic [LedW-1:0] LED_ON    = 2'd2;
  localparam logic [LedW-1:0] LED_BLINK = 2'd3;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_TIMEOUT_MS  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_HIGH_NEEDED = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_HIGH_CAP    = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_LOW_NEEDED  = 2'd3;

  // register reset values
  localparam logic [TimeW-1:0] TIMEOUT_MS_RST  = 32'd90000;
  localparam logic [HighW-1:0] HIGH_NEEDED_RST = 7'd20;
  localparam logic [HighW-1:0] HIGH_CAP_RST    = 7'd100;
  localparam logic [LowW-1:0]  LOW_NEEDED_RST  = 8'd20;

  localparam logic [LowW-1:0]  LOW_MAX = 8'hff;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic             start_pulse;
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic            timeout_status;
    logic            relay_status;
    logic [LedW-1:0] led_command;
  } result_t;

  typedef struct packed {
    logic [TimeW-1:0] timeout_ms;
    logic [HighW-1:0] high_needed;
    logic [HighW-1:0] high_cap;
    logic [LowW-1:0]  low_needed;
  } cfg_t;

endpackage

// File: hw/rtl/ptts_core.sv
// ptts_core: test state registers and the per-tick update
// depends on ptts_pkg
module ptts_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ptts_pkg::tick_t   tick,
  input  ptts_pkg::cfg_t    cfg,
  output ptts_pkg::result_t res
);

  logic                       pin_passed_r, pin_passed_nxt;
  logic                       timed_out_r, timed_out_nxt;
  logic                       timer_running_r, timer_running_nxt;
  logic                       report_pending_r, report_pending_nxt;
  logic [ptts_pkg::TimeW-1:0] start_time_r, start_time_nxt;
  logic [ptts_pkg::HighW-1:0] high_count_r, high_count_nxt;
  logic [ptts_pkg::LowW-1:0]  low_count_r, low_count_nxt;
  logic                       timeout_reg_r, timeout_reg_nxt;
  logic                       relay_reg_r, relay_reg_nxt;
  logic [ptts_pkg::LedW-1:0]  led;
  logic [ptts_pkg::TimeW-1:0] start_base;
  logic [ptts_pkg::TimeW-1:0] elapsed;

  // start time seen by the timer compare, after a possible fresh start
  assign start_base = (tick.cmd == ptts_pkg::CMD_START && tick.start_pulse) ?
                      tick.now_ms : start_time_r;
  assign elapsed    = tick.now_ms - start_base;

  always_comb begin
    pin_passed_nxt     = pin_passed_r;
    timed_out_nxt      = timed_out_r;
    timer_running_nxt  = timer_running_r;
    report_pending_nxt = report_pending_r;
    start_time_nxt     = start_time_r;
    high_count_nxt     = high_count_r;
    low_count_nxt      = low_count_r;
    timeout_reg_nxt    = timeout_reg_r;
    relay_reg_nxt      = relay_reg_r;
    led                = ptts_pkg::LED_NONE;
    unique case (tick.cmd) inside
      ptts_pkg::CMD_INIT: begin
        led                = ptts_pkg::LED_OFF;
        pin_passed_nxt     = 1'b0;
        timed_out_nxt      = 1'b0;
        timer_running_nxt  = 1'b0;
        report_pending_nxt = 1'b0;
        start_time_nxt     = '0;
      end
      ptts_pkg::CMD_PASS, ptts_pkg::CMD_FAIL: begin
        led = (tick.cmd == ptts_pkg::CMD_PASS) ? ptts_pkg::LED_ON
                                               : ptts_pkg::LED_BLINK;
        pin_passed_nxt     = 1'b0;
        timed_out_nxt      = 1'b0;
        timer_running_nxt  = 1'b0;
        report_pending_nxt = 1'b0;
        start_time_nxt     = '0;
        timeout_reg_nxt    = 1'b0;
        relay_reg_nxt      = 1'b0;
      end
      ptts_pkg::CMD_START: begin
        if (tick.start_pulse) begin
          led                = ptts_pkg::LED_OFF;
          pin_passed_nxt     = 1'b0;
          timed_out_nxt      = 1'b0;
          timer_running_nxt  = 1'b1;
          report_pending_nxt = 1'b0;
          start_time_nxt     = tick.now_ms;
          high_count_nxt     = '0;
          low_count_nxt      = '0;
          timeout_reg_nxt    = 1'b0;
          relay_reg_nxt      = 1'b0;
        end
        // pin sample
        if (pin_passed_nxt) begin
          high_count_nxt = '0;
          low_count_nxt  = '0;
        end else begin
          if (tick.pin_level) begin
            low_count_nxt = '0;
            if (high_count_nxt < cfg.high_cap)
              high_count_nxt = high_count_nxt + ptts_pkg::HighW'(1);
          end else if (high_count_nxt > cfg.high_needed) begin
            if (low_count_nxt != ptts_pkg::LOW_MAX)
              low_count_nxt = low_count_nxt + ptts_pkg::LowW'(1);
          end
          if (high_count_nxt > cfg.high_needed && low_count_nxt > cfg.low_needed) begin
            pin_passed_nxt = 1'b1;
            relay_reg_nxt  = 1'b1;
          end
        end
        // timeout check, reported one start tick later
        if (!timed_out_nxt) begin
          if (timer_running_nxt && elapsed > cfg.timeout_ms) begin
            timed_out_nxt      = 1'b1;
            report_pending_nxt = 1'b1;
          end
        end else if (report_pending_nxt) begin
          timeout_reg_nxt    = 1'b1;
          report_pending_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_passed_r     <= 1'b0;
      timed_out_r      <= 1'b0;
      timer_running_r  <= 1'b0;
      report_pending_r <= 1'b0;
      start_time_r     <= '0;
      high_count_r     <= '0;
      low_count_r      <= '0;
      timeout_reg_r    <= 1'b0;
      relay_reg_r      <= 1'b0;
    end else if (en) begin
      pin_passed_r     <= pin_passed_nxt;
      timed_out_r      <= timed_out_nxt;
      timer_running_r  <= timer_running_nxt;
      report_pending_r <= report_pending_nxt;
      start_time_r     <= start_time_nxt;
      high_count_r     <= high_count_nxt;
      low_count_r      <= low_count_nxt;
      timeout_reg_r    <= timeout_reg_nxt;
      relay_reg_r      <= relay_reg_nxt;
    end
  end

  assign res.timeout_status = timeout_reg_nxt;
  assign res.relay_status   = relay_reg_nxt;
  assign res.led_command    = led;

endmodule

// File: hw/rtl/pin_toggle_test_sequencer_top.sv
// pin_toggle_test_sequencer_top: input register, configuration registers,
// output register; depends on ptts_pkg and ptts_core
//
// Usage: each input beat is one poll tick (master command, start pulse, pin
// level, millisecond time); each tick gives exactly one output beat with the
// reported timeout and relay status and an led command. Both channels use
// valid/stall; a beat moves when valid is high and stall is low.
// A taken tick waits in the input register; once the output register is free,
// the tick updates the test state; its result enters the output register at
// the same edge. Throughput: one tick per cycle unless the receiver stalls;
// the update is one pass of short logic between input and output registers.
// When the receiver stalls the output register holds, the input register
// fills and in_stall rises, so at most two ticks are in flight.
// Configuration: write cfg_we with cfg_addr and cfg_wdata, only while no
// tick is in flight. Reset (rst_n low, synchronous) empties both registers,
// clears the test state and loads the register defaults.
module pin_toggle_test_sequencer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptts_pkg::CmdW-1:0]     in_cmd,
  input  logic                          in_start_pulse,
  input  logic                          in_pin_level,
  input  logic [ptts_pkg::TimeW-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_timeout_status,
  output logic                          out_relay_status,
  output logic [ptts_pkg::LedW-1:0]     out_led_command,
  input  logic                          cfg_we,
  input  logic [ptts_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [ptts_pkg::CfgDataW-1:0] cfg_wdata
);

  ptts_pkg::cfg_t    cfg_r;
  ptts_pkg::tick_t   tick_r;
  logic              tick_valid_r;
  ptts_pkg::result_t res, res_r;
  logic              out_valid_r;
  logic              adv;

  // output register frees up when empty or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = tick_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms  <= ptts_pkg::TIMEOUT_MS_RST;
      cfg_r.high_needed <= ptts_pkg::HIGH_NEEDED_RST;
      cfg_r.high_cap    <= ptts_pkg::HIGH_CAP_RST;
      cfg_r.low_needed  <= ptts_pkg::LOW_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ptts_pkg::REG_TIMEOUT_MS:  cfg_r.timeout_ms  <= cfg_wdata;
        ptts_pkg::REG_HIGH_NEEDED: cfg_r.high_needed <= cfg_wdata[ptts_pkg::HighW-1:0];
        ptts_pkg::REG_HIGH_CAP:    cfg_r.high_cap    <= cfg_wdata[ptts_pkg::HighW-1:0];
        ptts_pkg::REG_LOW_NEEDED:  cfg_r.low_needed  <= cfg_wdata[ptts_pkg::LowW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (!in_stall) begin
      tick_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick_r.cmd         <= in_cmd;
      tick_r.start_pulse <= in_start_pulse;
      tick_r.pin_level   <= in_pin_level;
      tick_r.now_ms      <= in_now_ms;
    end
  end

  ptts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (tick_valid_r && adv),
    .tick  (tick_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tick_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tick_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_timeout_status = res_r.timeout_status;
  assign out_relay_status   = res_r.relay_status;
  assign out_led_command    = res_r.led_command;

endmodule

// File: test/pin_toggle_test_sequencer_top_test.sv
// pin_toggle_test_sequencer_top_test: self-checking bench for the pin toggle test sequencer
// drives poll ticks with bursts and gaps, predicts every status beat; needs ptts_pkg and the top
`timescale 1ns / 1ps

module pin_toggle_test_sequencer_top_test;

  localparam int QuietLimit = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ptts_pkg::CmdW-1:0]     in_cmd = '0;
  logic                          in_start_pulse = 1'b0;
  logic                          in_pin_level = 1'b0;
  logic [ptts_pkg::TimeW-1:0]    in_now_ms = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_timeout_status;
  logic                          out_relay_status;
  logic [ptts_pkg::LedW-1:0]     out_led_command;
  logic                          cfg_we = 1'b0;
  logic [ptts_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [ptts_pkg::CfgDataW-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  pin_toggle_test_sequencer_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_start_pulse     (in_start_pulse),
    .in_pin_level       (in_pin_level),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_timeout_status (out_timeout_status),
    .out_relay_status   (out_relay_status),
    .out_led_command    (out_led_command),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  // predicted sequencer state
  ptts_pkg::cfg_t             thr;
  logic                       passed, timed_out, running, report_due;
  logic [ptts_pkg::TimeW-1:0] start_ms;
  logic [ptts_pkg::HighW-1:0] high_cnt;
  logic [ptts_pkg::LowW-1:0]  low_cnt;
  logic                       timeout_flag, relay_flag;

  ptts_pkg::result_t status_due_q[$];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  // sender and receiver pacing
  int                         gap_max = 0;
  int                         burst_left = 0;
  int                         stall_pct = 0;
  int                         hold_req = 0;
  int                         hold_left = 0;
  int                         run_left = 0;
  bit                         run_stall = 1'b0;
  logic [ptts_pkg::TimeW-1:0] cur_ms = 32'hffff_f000;

  function automatic void clear_test_state();
    passed     = 1'b0;
    timed_out  = 1'b0;
    running    = 1'b0;
    report_due = 1'b0;
    start_ms   = '0;
  endfunction

  function automatic ptts_pkg::result_t predict_tick_status(ptts_pkg::tick_t t);
    ptts_pkg::result_t          r;
    logic [ptts_pkg::TimeW-1:0] elapsed;
    r.led_command = ptts_pkg::LED_NONE;
    if (t.cmd == ptts_pkg::CMD_INIT) begin
      r.led_command = ptts_pkg::LED_OFF;
      clear_test_state();
    end else if (t.cmd == ptts_pkg::CMD_START) begin
      if (t.start_pulse) begin
        clear_test_state();
        running       = 1'b1;
        high_cnt      = '0;
        low_cnt       = '0;
        start_ms      = t.now_ms;
        timeout_flag  = 1'b0;
        relay_flag    = 1'b0;
        r.led_command = ptts_pkg::LED_OFF;
      end
      // a passed pin only resets the counters
      if (passed) begin
        high_cnt = '0;
        low_cnt  = '0;
      end else begin
        if (t.pin_level) begin
          low_cnt = '0;
          if (high_cnt < thr.high_cap) high_cnt++;
        end else if (high_cnt > thr.high_needed && low_cnt != ptts_pkg::LOW_MAX) begin
          low_cnt++;
        end
        if (high_cnt > thr.high_needed && low_cnt > thr.low_needed) begin
          passed     = 1'b1;
          relay_flag = 1'b1;
        end
      end
      elapsed = t.now_ms - start_ms;
      if (!timed_out) begin
        if (running && elapsed > thr.timeout_ms) begin
          timed_out  = 1'b1;
          report_due = 1'b1;
        end
      end else if (report_due) begin
        timeout_flag = 1'b1;
        report_due   = 1'b0;
      end
    end else if (t.cmd == ptts_pkg::CMD_PASS || t.cmd == ptts_pkg::CMD_FAIL) begin
      r.led_command = (t.cmd == ptts_pkg::CMD_PASS) ? ptts_pkg::LED_ON : ptts_pkg::LED_BLINK;
      clear_test_state();
      relay_flag   = 1'b0;
      timeout_flag = 1'b0;
    end
    r.timeout_status = timeout_flag;
    r.relay_status   = relay_flag;
    return r;
  endfunction

  function automatic logic [ptts_pkg::CmdW-1:0] random_cmd();
    case ($urandom_range(0, 4))
      0: return ptts_pkg::CMD_INIT;
      1: return ptts_pkg::CMD_PASS;
      2: return ptts_pkg::CMD_FAIL;
      3: return ptts_pkg::CMD_START;
      default: return ptts_pkg::CmdW'($urandom_range(0, 65535));
    endcase
  endfunction

  // one tick beat, with a random gap at the head of each burst
  task automatic send_tick(logic [ptts_pkg::CmdW-1:0] cmd, logic pulse, logic level,
                           logic [ptts_pkg::TimeW-1:0] now);
    ptts_pkg::tick_t t;
    int              gap;
    t = '{cmd: cmd, start_pulse: pulse, pin_level: level, now_ms: now};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_start_pulse <= pulse;
    in_pin_level   <= level;
    in_now_ms      <= now;
    do @(posedge clk); while (in_stall);
    status_due_q.push_back(predict_tick_status(t));
    burst_left--;
  endtask

  task automatic drain_status();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [ptts_pkg::CfgAddrW-1:0] idx,
                           logic [ptts_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptts_pkg::REG_TIMEOUT_MS:  thr.timeout_ms  = val;
      ptts_pkg::REG_HIGH_NEEDED: thr.high_needed = val[ptts_pkg::HighW-1:0];
      ptts_pkg::REG_HIGH_CAP:    thr.high_cap    = val[ptts_pkg::HighW-1:0];
      ptts_pkg::REG_LOW_NEEDED:  thr.low_needed  = val[ptts_pkg::LowW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_thresholds(logic [ptts_pkg::TimeW-1:0] tmo, int hn, int cap, int ln);
    drain_status();
    write_reg(ptts_pkg::REG_TIMEOUT_MS, tmo);
    write_reg(ptts_pkg::REG_HIGH_NEEDED, ptts_pkg::CfgDataW'(hn));
    write_reg(ptts_pkg::REG_HIGH_CAP, ptts_pkg::CfgDataW'(cap));
    write_reg(ptts_pkg::REG_LOW_NEEDED, ptts_pkg::CfgDataW'(ln));
  endtask

  // commands, ignored words, pulses, pass and timeout reporting
  task automatic test_commands_and_flags();
    send_tick(16'hffff, 1'b1, 1'b1, 32'hffff_ffff);
    send_tick(16'h0004, 1'b1, 1'b0, 32'h0000_0000);
    // start without a pulse before any test was begun
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b1, 32'h0000_0000);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'hffff_ffff);
    send_tick(ptts_pkg::CMD_INIT, 1'b1, 1'b1, 32'h5555_aaaa);
    load_thresholds(32'd0, 0, 127, 0);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, 32'hffff_fff0);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'hffff_fff0);
    // pin already passed, elapsed time wraps past zero
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b1, 32'd5);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'd6);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b1, 32'd7);
    send_tick(ptts_pkg::CMD_PASS, 1'b0, 1'b0, 32'd8);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, 32'd100);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'd100);
    send_tick(ptts_pkg::CMD_FAIL, 1'b1, 1'b1, 32'd101);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b0, 32'd200);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'd201);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'd202);
    // init keeps the reported flags
    send_tick(ptts_pkg::CMD_INIT, 1'b0, 1'b0, 32'd203);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'd500);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, 32'd0);
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, 32'hffff_ffff);
  endtask

  // high count at its cap, low count saturating, a zero cap
  task automatic test_counter_limits();
    load_thresholds(32'hffff_ffff, 126, 127, 0);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, $urandom());
    repeat (130) send_tick(ptts_pkg::CMD_START, 1'b0, 1'b1, $urandom());
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, $urandom());
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, $urandom());

    load_thresholds(32'hffff_ffff, 0, 127, 254);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, $urandom());
    send_tick(ptts_pkg::CMD_START, 1'b0, 1'b1, $urandom());
    repeat (255) send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, $urandom());
    // init drops the pass but keeps the full low counter
    send_tick(ptts_pkg::CMD_INIT, 1'b0, 1'b0, $urandom());
    repeat (3) send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, $urandom());

    load_thresholds(32'hffff_ffff, 0, 0, 0);
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, $urandom());
    repeat (5) send_tick(ptts_pkg::CMD_START, 1'b0, 1'b1, $urandom());
    repeat (3) send_tick(ptts_pkg::CMD_START, 1'b0, 1'b0, $urandom());
  endtask

  // mostly well-formed test sessions with noise ticks in between
  task automatic test_random_sessions(int n, int gaps, int stalls,
                                      logic [ptts_pkg::TimeW-1:0] tmo,
                                      int hn, int cap, int ln, int step_max);
    int   sent;
    int   len;
    int   hi_len;
    logic lvl;
    load_thresholds(tmo, hn, cap, ln);
    gap_max   = gaps;
    stall_pct = stalls;
    sent      = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 75) begin
        len    = $urandom_range(2, 60);
        hi_len = $urandom_range(0, len);
        cur_ms += $urandom_range(0, step_max);
        send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, cur_ms);
        sent++;
        for (int i = 0; i < len; i++) begin
          cur_ms += $urandom_range(0, step_max);
          lvl = (i < hi_len);
          if ($urandom_range(0, 9) == 0) lvl = ~lvl;
          if ($urandom_range(0, 99) < 92)
            send_tick(ptts_pkg::CMD_START, $urandom_range(0, 49) == 0, lvl, cur_ms);
          else
            send_tick(random_cmd(), 1'($urandom_range(0, 1)), lvl, cur_ms);
          sent++;
        end
      end else begin
        send_tick(random_cmd(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 1) == 1) ? $urandom() : cur_ms);
        sent++;
      end
    end
  endtask

  // long receiver hold while ticks keep coming, then a full pause
  task automatic test_backpressure();
    drain_status();
    gap_max   = 0;
    stall_pct = 0;
    hold_req  = 80;
    send_tick(ptts_pkg::CMD_START, 1'b1, 1'b1, cur_ms);
    repeat (40) begin
      cur_ms += $urandom_range(0, 4);
      send_tick(ptts_pkg::CMD_START, 1'b0, 1'($urandom_range(0, 1)), cur_ms);
    end
    drain_status();
  endtask

  // receiver stall pattern in runs, plus a counted hold when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(0, 99) < stall_pct);
        run_left  = $urandom_range(1, 8);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // status beat check and watchdog
  always @(posedge clk) begin
    ptts_pkg::result_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (status_due_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: status beat with none expected: timeout %0b relay %0b led %0d",
                   $time, out_timeout_status, out_relay_status, out_led_command);
        end else begin
          want = status_due_q.pop_front();
          if (out_timeout_status !== want.timeout_status) begin
            mismatch_count++;
            $display("%0t: timeout_status expected %0b got %0b", $time,
                     want.timeout_status, out_timeout_status);
          end
          if (out_relay_status !== want.relay_status) begin
            mismatch_count++;
            $display("%0t: relay_status expected %0b got %0b", $time,
                     want.relay_status, out_relay_status);
          end
          if (out_led_command !== want.led_command) begin
            mismatch_count++;
            $display("%0t: led_command expected %0d got %0d", $time,
                     want.led_command, out_led_command);
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL pin_toggle_test_sequencer_top");
        $finish;
      end
    end
  end

  initial begin
    thr.timeout_ms  = ptts_pkg::TIMEOUT_MS_RST;
    thr.high_needed = ptts_pkg::HIGH_NEEDED_RST;
    thr.high_cap    = ptts_pkg::HIGH_CAP_RST;
    thr.low_needed  = ptts_pkg::LOW_NEEDED_RST;
    clear_test_state();
    high_cnt     = '0;
    low_cnt      = '0;
    timeout_flag = 1'b0;
    relay_flag   = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_commands_and_flags();
    test_counter_limits();
    test_random_sessions(450, 0, 0, 32'd300, $urandom_range(0, 10),
                         $urandom_range(1, 127), $urandom_range(0, 10), 8);
    test_random_sessions(400, 6, 30, 32'd150, $urandom_range(0, 10),
                         $urandom_range(1, 127), $urandom_range(0, 10), 10);
    test_backpressure();
    test_random_sessions(300, 20, 60, 32'hffff_ffff, 0, 1, 0, 1000);
    drain_status();

    if (mismatch_count == 0 && status_due_q.size() == 0) begin
      $display("PASS pin_toggle_test_sequencer_top");
    end else begin
      $display("FAIL pin_toggle_test_sequencer_top");
    end
    $finish;
  end

endmodule

// File: pin_toggle_test_sequencer_top.f
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_core.sv
hw/rtl/pin_toggle_test_sequencer_top.sv
test/pin_toggle_test_sequencer_top_test.sv
